@@ hw/rtl/rps_pkg.sv @@
// package: constants, control word types and microcode rom for the prescaler split
`timescale 1ns / 1ps

package rps_pkg;

   localparam int ASYNC_MAX = 128;
   localparam int SYNC_MAX  = 32768;
   localparam int ASYNC_LOG = 7;

   localparam int RATIO_W = 23;
   localparam int ASYNC_W = 7;
   localparam int SYNC_W  = 15;
   localparam int DIV_W   = 8;   // candidate divisor, holds ASYNC_MAX
   localparam int PREVQ_W = 16;  // quotient known to be at most SYNC_MAX
   localparam int CNT_W   = 5;   // quotient bit counter, holds RATIO_W
   localparam int PC_W    = 5;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_INIT_D,
      OP_DIV_START,
      OP_DIV_STEP,
      OP_DEC_D,
      OP_SET_FALLBACK,
      OP_SET_EXACT,
      OP_SET_BACK,
      OP_SET_REJ,
      OP_SET_SMALL,
      OP_SET_ALIGN,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_REJECT,
      COND_SMALL,
      COND_ALIGNED,
      COND_DIV_MORE,
      COND_REM_ZERO,
      COND_OVERFLOW,
      COND_D_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   // program addresses
   localparam logic [PC_W-1:0] A_WAIT      = 5'd0;
   localparam logic [PC_W-1:0] A_CHK_REJ   = 5'd1;
   localparam logic [PC_W-1:0] A_CHK_SMALL = 5'd2;
   localparam logic [PC_W-1:0] A_CHK_ALIGN = 5'd3;
   localparam logic [PC_W-1:0] A_INIT_D    = 5'd4;
   localparam logic [PC_W-1:0] A_LOOP      = 5'd5;
   localparam logic [PC_W-1:0] A_DIV       = 5'd6;
   localparam logic [PC_W-1:0] A_CHK_REM   = 5'd7;
   localparam logic [PC_W-1:0] A_CHK_OVF   = 5'd8;
   localparam logic [PC_W-1:0] A_NEXT_D    = 5'd9;
   localparam logic [PC_W-1:0] A_FALLBACK  = 5'd10;
   localparam logic [PC_W-1:0] A_EXACT     = 5'd11;
   localparam logic [PC_W-1:0] A_BACK      = 5'd12;
   localparam logic [PC_W-1:0] A_REJ       = 5'd13;
   localparam logic [PC_W-1:0] A_SMALL     = 5'd14;
   localparam logic [PC_W-1:0] A_ALIGN     = 5'd15;
   localparam logic [PC_W-1:0] A_EMIT      = 5'd16;
   localparam logic [PC_W-1:0] A_DONE      = 5'd17;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] addr);
      ucode_type w;
      w = '{op: OP_NOP, cond: COND_ALWAYS, target: A_WAIT};
      unique case (addr)
         A_WAIT:      w = '{op: OP_LOAD,         cond: COND_NO_REQ,   target: A_WAIT};
         A_CHK_REJ:   w = '{op: OP_NOP,          cond: COND_REJECT,   target: A_REJ};
         A_CHK_SMALL: w = '{op: OP_NOP,          cond: COND_SMALL,    target: A_SMALL};
         A_CHK_ALIGN: w = '{op: OP_NOP,          cond: COND_ALIGNED,  target: A_ALIGN};
         A_INIT_D:    w = '{op: OP_INIT_D,       cond: COND_NEVER,    target: A_WAIT};
         A_LOOP:      w = '{op: OP_DIV_START,    cond: COND_NEVER,    target: A_WAIT};
         A_DIV:       w = '{op: OP_DIV_STEP,     cond: COND_DIV_MORE, target: A_DIV};
         A_CHK_REM:   w = '{op: OP_NOP,          cond: COND_REM_ZERO, target: A_EXACT};
         A_CHK_OVF:   w = '{op: OP_NOP,          cond: COND_OVERFLOW, target: A_BACK};
         A_NEXT_D:    w = '{op: OP_DEC_D,        cond: COND_D_MORE,   target: A_LOOP};
         A_FALLBACK:  w = '{op: OP_SET_FALLBACK, cond: COND_ALWAYS,   target: A_EMIT};
         A_EXACT:     w = '{op: OP_SET_EXACT,    cond: COND_ALWAYS,   target: A_EMIT};
         A_BACK:      w = '{op: OP_SET_BACK,     cond: COND_ALWAYS,   target: A_EMIT};
         A_REJ:       w = '{op: OP_SET_REJ,      cond: COND_ALWAYS,   target: A_EMIT};
         A_SMALL:     w = '{op: OP_SET_SMALL,    cond: COND_ALWAYS,   target: A_EMIT};
         A_ALIGN:     w = '{op: OP_SET_ALIGN,    cond: COND_NEVER,    target: A_WAIT};
         A_EMIT:      w = '{op: OP_EMIT,         cond: COND_OUT_BUSY, target: A_EMIT};
         A_DONE:      w = '{op: OP_NOP,          cond: COND_ALWAYS,   target: A_WAIT};
         default:     w = '{op: OP_NOP,          cond: COND_ALWAYS,   target: A_WAIT};
      endcase
      return w;
   endfunction

endpackage

@@ hw/rtl/rtc_prescaler_split.sv @@
// top level: microcoded split of a clock division ratio into async and sync prescalers
`timescale 1ns / 1ps

// Takes one ratio per transfer and returns one result. A microcode rom drives a small
// datapath: a restoring divider that produces one quotient bit per cycle, a candidate
// divisor register and result registers. Rejected, small and aligned ratios are settled by
// checks before any division. Other ratios walk the async divisor down from 128, and each
// candidate costs a full division plus setup and checks, so the divider loop dominates.
// A new ratio is taken only once the sequencer is back at its wait step; the result
// register holds a finished result until it is taken, so the next ratio can already
// be accepted.
module rtc_prescaler_split
   import rps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [RATIO_W-1:0]  req_ratio,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ASYNC_W-1:0]  rsp_async_div_minus_one,
   output logic [SYNC_W-1:0]   rsp_sync_div_minus_one,
   output logic                rsp_rejected
);

   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [RATIO_W-1:0] ratio_ff, ratio_in;
   logic [DIV_W-1:0]   d_ff, d_in;
   logic [RATIO_W-1:0] q_ff, q_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PREVQ_W-1:0] prevq_ff, prevq_in;
   logic [ASYNC_W-1:0] res_a_ff, res_a_in;
   logic [SYNC_W-1:0]  res_s_ff, res_s_in;
   logic               res_rej_ff, res_rej_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ASYNC_W-1:0] rsp_a_ff, rsp_a_in;
   logic [SYNC_W-1:0]  rsp_s_ff, rsp_s_in;
   logic               rsp_rej_ff, rsp_rej_in;

   ucode_type          uw;
   logic               take_jump;
   logic               req_accept;
   logic               out_busy;
   logic [DIV_W:0]     trial;
   logic               trial_ge;
   logic               over_sync;

   assign uw         = ucode_rom(pc_ff);
   assign req_stall  = (uw.op != OP_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign out_busy   = rsp_valid_ff && rsp_stall;

   assign trial     = {rem_ff, q_ff[RATIO_W-1]};
   assign trial_ge  = (trial >= {1'b0, d_ff});
   assign over_sync = (ratio_ff > RATIO_W'(SYNC_MAX));

   always_comb begin
      case (uw.cond)
         COND_NEVER:    take_jump = 1'b0;
         COND_ALWAYS:   take_jump = 1'b1;
         COND_NO_REQ:   take_jump = !req_accept;
         COND_REJECT:   take_jump = (ratio_ff == '0) ||
                                    (ratio_ff > RATIO_W'(ASYNC_MAX * SYNC_MAX));
         COND_SMALL:    take_jump = (ratio_ff < RATIO_W'(ASYNC_MAX));
         COND_ALIGNED:  take_jump = (ratio_ff[ASYNC_LOG-1:0] == '0);
         COND_DIV_MORE: take_jump = (cnt_ff != CNT_W'(1));
         COND_REM_ZERO: take_jump = (rem_ff == '0);
         COND_OVERFLOW: take_jump = (q_ff > RATIO_W'(SYNC_MAX));
         COND_D_MORE:   take_jump = (d_ff > DIV_W'(2));
         COND_OUT_BUSY: take_jump = out_busy;
         default:       take_jump = 1'b0;
      endcase
   end

   assign pc_in = take_jump ? uw.target : pc_ff + PC_W'(1);

   always_comb begin
      ratio_in   = ratio_ff;
      d_in       = d_ff;
      q_in       = q_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      prevq_in   = prevq_ff;
      res_a_in   = res_a_ff;
      res_s_in   = res_s_ff;
      res_rej_in = res_rej_ff;
      rsp_a_in   = rsp_a_ff;
      rsp_s_in   = rsp_s_ff;
      rsp_rej_in = rsp_rej_ff;
      // a taken result frees the output register
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (uw.op)
         OP_NOP: begin
         end
         OP_LOAD: begin
            if (req_accept) begin
               ratio_in = req_ratio;
            end
         end
         OP_INIT_D: begin
            d_in     = DIV_W'(ASYNC_MAX);
            prevq_in = '0;
         end
         OP_DIV_START: begin
            q_in   = ratio_ff;
            rem_in = '0;
            cnt_in = CNT_W'(RATIO_W);
         end
         OP_DIV_STEP: begin
            // restoring division, one quotient bit per cycle
            if (trial_ge) begin
               rem_in = DIV_W'(trial - {1'b0, d_ff});
            end else begin
               rem_in = trial[DIV_W-1:0];
            end
            q_in   = {q_ff[RATIO_W-2:0], trial_ge};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         OP_DEC_D: begin
            d_in     = d_ff - DIV_W'(1);
            prevq_in = q_ff[PREVQ_W-1:0];
         end
         OP_SET_FALLBACK: begin
            // no factor: divisor 1, or 2 when the ratio alone overflows the sync stage
            res_rej_in = 1'b0;
            if (over_sync) begin
               res_a_in = ASYNC_W'(1);
               res_s_in = SYNC_W'((ratio_ff >> 1) - RATIO_W'(1));
            end else begin
               res_a_in = '0;
               res_s_in = SYNC_W'(ratio_ff - RATIO_W'(1));
            end
         end
         OP_SET_EXACT: begin
            res_rej_in = 1'b0;
            res_a_in   = ASYNC_W'(d_ff - DIV_W'(1));
            res_s_in   = SYNC_W'(q_ff - RATIO_W'(1));
         end
         OP_SET_BACK: begin
            // step back to the previous, larger candidate
            res_rej_in = 1'b0;
            res_a_in   = d_ff[ASYNC_W-1:0];
            res_s_in   = SYNC_W'(prevq_ff - PREVQ_W'(1));
         end
         OP_SET_REJ: begin
            res_rej_in = 1'b1;
            res_a_in   = '0;
            res_s_in   = '0;
         end
         OP_SET_SMALL: begin
            res_rej_in = 1'b0;
            res_a_in   = ASYNC_W'(ratio_ff - RATIO_W'(1));
            res_s_in   = '0;
         end
         OP_SET_ALIGN: begin
            res_rej_in = 1'b0;
            res_a_in   = ASYNC_W'(ASYNC_MAX - 1);
            res_s_in   = SYNC_W'((ratio_ff >> ASYNC_LOG) - RATIO_W'(1));
         end
         OP_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_a_in     = res_a_ff;
               rsp_s_in     = res_s_ff;
               rsp_rej_in   = res_rej_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= A_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ratio_ff   <= ratio_in;
      d_ff       <= d_in;
      q_ff       <= q_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      prevq_ff   <= prevq_in;
      res_a_ff   <= res_a_in;
      res_s_ff   <= res_s_in;
      res_rej_ff <= res_rej_in;
      rsp_a_ff   <= rsp_a_in;
      rsp_s_ff   <= rsp_s_in;
      rsp_rej_ff <= rsp_rej_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_async_div_minus_one = rsp_a_ff;
   assign rsp_sync_div_minus_one  = rsp_s_ff;
   assign rsp_rejected            = rsp_rej_ff;

endmodule

@@ hw/rtl/rps_checker.sv @@
// port checker for the prescaler split, bound to the top level
`timescale 1ns / 1ps

module rps_checker
   import rps_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [ASYNC_W-1:0] rsp_async_div_minus_one,
   input logic [SYNC_W-1:0]  rsp_sync_div_minus_one,
   input logic               rsp_rejected
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_async_div_minus_one) &&
         $stable(rsp_sync_div_minus_one) && $stable(rsp_rejected))
      else $error("stalled result changed");

   // rejected results carry zero prescaler values
   a_rej_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |->
         rsp_async_div_minus_one == '0 && rsp_sync_div_minus_one == '0)
      else $error("rejected result with nonzero prescaler");

   // one item at a time: after a transfer in, the sequencer is busy
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again right after a transfer");

   // a result never appears in the cycle after a transfer in
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early");

endmodule

bind rtc_prescaler_split rps_checker u_rps_checker (
   .clock                   (clock),
   .reset                   (reset),
   .req_valid               (req_valid),
   .req_stall               (req_stall),
   .rsp_valid               (rsp_valid),
   .rsp_stall               (rsp_stall),
   .rsp_async_div_minus_one (rsp_async_div_minus_one),
   .rsp_sync_div_minus_one  (rsp_sync_div_minus_one),
   .rsp_rejected            (rsp_rejected)
);
